FILE: design/mhpq_pkg.sv
// Shared types, codes and constants of the max-heap priority queue.
package mhpq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int CNT_W         = 7;
  localparam int KEY_W         = 16;
  localparam int HANDLE_W      = 16;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);

  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;
  localparam logic [1:0] STATUS_RSVD  = 2'd3;

  typedef struct packed {
    logic                req_type;
    logic [KEY_W-1:0]    priority_key;
    logic [HANDLE_W-1:0] participant_id;
    logic [HANDLE_W-1:0] route_id;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0] out_participant;
    logic [HANDLE_W-1:0] out_route;
    logic [CNT_W-1:0]    entry_count;
  } resp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] participant;
    logic [HANDLE_W-1:0] route;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_LOAD,
    S_DN_CHK,
    S_DN_L,
    S_DN_R,
    S_DN_DEC,
    S_DONE
  } state_t;

endpackage

FILE: design/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/max_heap_priority_queue_unit.sv
// Top level of the binary max-heap priority queue with its sequencer.
//
// The heap lives in one entry memory with one write and one registered read port, and a small
// sequencer walks it one level at a time, keeping the moving entry in a register and writing
// each displaced entry once. An insert reads and compares each parent in turn until it meets
// a parent with a key at least as large or reaches the root; an extract reads the root and then
// the last entry, and for each level reads the left child, the right child if there is one,
// and then decides whether to swap, until it comes to rest. A request that meets a full or
// empty heap goes straight to the done state. A finished result waits in an output register,
// and the next request is taken while it waits. Memory contents are not cleared at reset; only
// entries below the count are ever read. The capacity register should be written only while
// the block is idle; the block itself does not enforce this. The effective limit is the
// smaller of the capacity and the memory depth.
module max_heap_priority_queue_unit #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mhpq_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mhpq_pkg::resp_t            out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mhpq_pkg::CNT_W-1:0] cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = mhpq_pkg::CNT_W;
  localparam int IW = (AW > CW) ? AW : CW;
  localparam logic [IW:0] DEPTH_W = (IW+1)'(DEPTH);

  mhpq_pkg::state_t state, state_next;
  logic [CW-1:0]    count, count_next;
  logic [CW-1:0]    cap;
  logic [IW-1:0]    idx, idx_next;
  logic [IW-1:0]    par_idx, par_idx_next;
  logic [IW-1:0]    child_idx, child_idx_next;
  mhpq_pkg::entry_t cur, cur_next;
  mhpq_pkg::entry_t child, child_next;
  mhpq_pkg::entry_t res_entry, res_entry_next;
  logic [1:0]       res_status, res_status_next;
  logic             load_out;

  logic             we;
  logic [AW-1:0]    waddr;
  mhpq_pkg::entry_t wdata;
  logic [AW-1:0]    raddr;
  logic [mhpq_pkg::ENTRY_W-1:0] ram_rdata;
  mhpq_pkg::entry_t rdata;

  logic [IW:0]   left_w;
  logic [IW:0]   right_w;
  logic [IW:0]   n_w;
  logic [IW-1:0] up_parent;
  logic          full;

  mhpq_ram #(
    .WIDTH (mhpq_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  assign rdata     = ram_rdata;
  assign left_w    = {idx, 1'b1};
  assign right_w   = left_w + 1'b1;
  assign n_w       = (IW+1)'(count);
  assign up_parent = (idx - 1'b1) >> 1;
  assign full      = (count >= cap) || (n_w >= DEPTH_W);
  assign in_stall  = (state != mhpq_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mhpq_pkg::S_IDLE;
      count     <= '0;
      cap       <= mhpq_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        cap <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    par_idx    <= par_idx_next;
    child_idx  <= child_idx_next;
    cur        <= cur_next;
    child      <= child_next;
    res_entry  <= res_entry_next;
    res_status <= res_status_next;
    if (load_out) begin
      out_data.status          <= res_status;
      out_data.out_key         <= res_entry.key;
      out_data.out_participant <= res_entry.participant;
      out_data.out_route       <= res_entry.route;
      out_data.entry_count     <= count;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    par_idx_next    = par_idx;
    child_idx_next  = child_idx;
    cur_next        = cur;
    child_next      = child;
    res_entry_next  = res_entry;
    res_status_next = res_status;
    load_out        = 1'b0;
    we              = 1'b0;
    waddr           = idx[AW-1:0];
    wdata           = cur;
    raddr           = '0;
    unique case (state)
      mhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          cur_next.key         = in_data.priority_key;
          cur_next.participant = in_data.participant_id;
          cur_next.route       = in_data.route_id;
          res_status_next      = mhpq_pkg::STATUS_OK;
          res_entry_next       = '0;
          if (in_data.req_type == mhpq_pkg::REQ_INSERT) begin
            if (full) begin
              res_status_next = mhpq_pkg::STATUS_FULL;
              state_next      = mhpq_pkg::S_DONE;
            end else begin
              idx_next   = IW'(count);
              state_next = mhpq_pkg::S_UP_CHK;
            end
          end else if (count == '0) begin
            res_status_next = mhpq_pkg::STATUS_EMPTY;
            state_next      = mhpq_pkg::S_DONE;
          end else begin
            count_next = count - 1'b1;
            state_next = mhpq_pkg::S_EX_ROOT;
          end
        end
      end
      mhpq_pkg::S_UP_CHK: begin
        if (idx == '0) begin
          we         = 1'b1;
          count_next = count + 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          par_idx_next = up_parent;
          raddr        = up_parent[AW-1:0];
          state_next   = mhpq_pkg::S_UP_CMP;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        we = 1'b1;
        if (rdata.key >= cur.key) begin
          count_next = count + 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          wdata      = rdata;
          idx_next   = par_idx;
          state_next = mhpq_pkg::S_UP_CHK;
        end
      end
      mhpq_pkg::S_EX_ROOT: begin
        state_next = mhpq_pkg::S_EX_LAST;
      end
      mhpq_pkg::S_EX_LAST: begin
        res_entry_next = rdata;
        raddr          = n_w[AW-1:0];
        state_next     = mhpq_pkg::S_EX_LOAD;
      end
      mhpq_pkg::S_EX_LOAD: begin
        cur_next = rdata;
        idx_next = '0;
        if (count == '0) begin
          state_next = mhpq_pkg::S_DONE;
        end else begin
          state_next = mhpq_pkg::S_DN_CHK;
        end
      end
      mhpq_pkg::S_DN_CHK: begin
        if (left_w >= n_w) begin
          we         = 1'b1;
          state_next = mhpq_pkg::S_DONE;
        end else begin
          raddr      = left_w[AW-1:0];
          state_next = mhpq_pkg::S_DN_L;
        end
      end
      mhpq_pkg::S_DN_L: begin
        child_next     = rdata;
        child_idx_next = left_w[IW-1:0];
        if (right_w < n_w) begin
          raddr      = right_w[AW-1:0];
          state_next = mhpq_pkg::S_DN_R;
        end else begin
          state_next = mhpq_pkg::S_DN_DEC;
        end
      end
      mhpq_pkg::S_DN_R: begin
        if (rdata.key > child.key) begin
          child_next     = rdata;
          child_idx_next = right_w[IW-1:0];
        end
        state_next = mhpq_pkg::S_DN_DEC;
      end
      mhpq_pkg::S_DN_DEC: begin
        we = 1'b1;
        if (child.key > cur.key) begin
          wdata      = child;
          idx_next   = child_idx;
          state_next = mhpq_pkg::S_DN_CHK;
        end else begin
          state_next = mhpq_pkg::S_DONE;
        end
      end
      mhpq_pkg::S_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/mhpq_checker.sv
// Port-level checker of the max-heap priority queue and its bind to the top level.
module mhpq_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input mhpq_pkg::req_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input mhpq_pkg::resp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed or was dropped.");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("Block not idle and empty after reset.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("Block accepted a request without going busy.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != mhpq_pkg::STATUS_RSVD)
    else $error("Result carries a reserved status code.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != mhpq_pkg::STATUS_OK |->
      out_data.out_key == '0 && out_data.out_participant == '0 && out_data.out_route == '0)
    else $error("Failed request returned a non-zero entry.");

endmodule

bind max_heap_priority_queue_unit mhpq_checker u_mhpq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
